// File: rtl/mqfb_pkg.sv
// Shared types, constants and the coefficient table of the multichannel Q15 band-pass FIR.
// Used by mqfb_mac and the top level; depends on nothing.
package mqfb_pkg;

   localparam int TAPS_DEF    = 129;
   localparam int CH_MAX_DEF  = 64;
   localparam int WIN_MAX_DEF = 512;
   localparam int HIST_LEN    = 128;
   localparam int TAIL_AW     = 7;
   localparam int ACC_W       = 40;
   localparam int CFG_W       = 12;

   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
   localparam logic [1:0] REG_HOP_LENGTH    = 2'd2;
   localparam logic [1:0] REG_UNLISTED      = 2'd3;

   typedef enum logic [2:0] {
      ST_TCLR,
      ST_IDLE,
      ST_FIR,
      ST_DRAIN,
      ST_RESULT,
      ST_REB_RD,
      ST_REB_WR
   } state_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;

   // first half of the symmetric coefficient set, taps 0..64
   function automatic logic signed [15:0] coef_half(input logic [6:0] k);
      logic signed [15:0] c;
      case (k)
         7'd0: c = -16'sd12;    7'd1: c = -16'sd23;    7'd2: c = -16'sd18;
         7'd3: c = 16'sd1;      7'd4: c = 16'sd15;     7'd5: c = 16'sd11;
         7'd6: c = -16'sd2;     7'd7: c = -16'sd2;     7'd8: c = 16'sd20;
         7'd9: c = 16'sd45;     7'd10: c = 16'sd43;    7'd11: c = 16'sd12;
         7'd12: c = -16'sd13;   7'd13: c = -16'sd3;    7'd14: c = 16'sd27;
         7'd15: c = 16'sd26;    7'd16: c = -16'sd27;   7'd17: c = -16'sd89;
         7'd18: c = -16'sd93;   7'd19: c = -16'sd38;   7'd20: c = 16'sd3;
         7'd21: c = -16'sd31;   7'd22: c = -16'sd104;  7'd23: c = -16'sd107;
         7'd24: c = 16'sd0;     7'd25: c = 16'sd127;   7'd26: c = 16'sd144;
         7'd27: c = 16'sd51;    7'd28: c = -16'sd6;    7'd29: c = 16'sd87;
         7'd30: c = 16'sd251;   7'd31: c = 16'sd283;   7'd32: c = 16'sd103;
         7'd33: c = -16'sd116;  7'd34: c = -16'sd144;  7'd35: c = 16'sd16;
         7'd36: c = 16'sd97;    7'd37: c = -16'sd107;  7'd38: c = -16'sd447;
         7'd39: c = -16'sd557;  7'd40: c = -16'sd295;  7'd41: c = 16'sd38;
         7'd42: c = 16'sd43;    7'd43: c = -16'sd266;  7'd44: c = -16'sd414;
         7'd45: c = -16'sd33;   7'd46: c = 16'sd623;   7'd47: c = 16'sd901;
         7'd48: c = 16'sd535;   7'd49: c = 16'sd47;    7'd50: c = 16'sd162;
         7'd51: c = 16'sd868;   7'd52: c = 16'sd1271;  7'd53: c = 16'sd612;
         7'd54: c = -16'sd696;  7'd55: c = -16'sd1363; 7'd56: c = -16'sd738;
         7'd57: c = 16'sd166;   7'd58: c = -16'sd415;  7'd59: c = -16'sd2839;
         7'd60: c = -16'sd5033; 7'd61: c = -16'sd4115; 7'd62: c = 16'sd620;
         7'd63: c = 16'sd6398;  7'd64: c = 16'sd8995;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [15:0] coef_at(input logic [7:0] k);
      logic [7:0] m;
      m = (k <= 8'd64) ? k : 8'd128 - k;
      return coef_half(m[6:0]);
   endfunction

endpackage

// File: rtl/mqfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mqfb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mqfb_mac.sv
// Shared multiply-accumulate unit: registered product, exact accumulator, round and saturate.
// Depends on mqfb_pkg.
module mqfb_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  mqfb_pkg::mac_ctrl_type ctrl,
   input  logic signed [15:0]   coef,
   input  logic signed [15:0]   sample,
   output logic signed [15:0]   result
);

   logic signed [31:0]                 prod_ff;
   logic                               prod_vld_ff;
   logic signed [mqfb_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mqfb_pkg::ACC_W-1:0]  rounded;
   logic signed [mqfb_pkg::ACC_W-1:0]  shifted;

   always_ff @(posedge clock) begin
      prod_ff <= coef * sample;
      if (reset || ctrl.clear) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= ctrl.valid;
         if (prod_vld_ff) begin
            acc_ff <= acc_ff + mqfb_pkg::ACC_W'(prod_ff);
         end
      end
   end

   always_comb begin
      rounded = acc_ff + mqfb_pkg::ACC_W'(16384);
      shifted = rounded >>> 15;
      if (shifted > mqfb_pkg::ACC_W'(32767)) begin
         result = 16'sh7fff;
      end else if (shifted < -mqfb_pkg::ACC_W'(32768)) begin
         result = 16'sh8000;
      end else begin
         result = shifted[15:0];
      end
   end

endmodule

// File: rtl/multichannel_q15_fir_bandpass_unit.sv
// Top level of the multichannel Q15 band-pass FIR: sequencer, window and tail stores.
// Depends on mqfb_pkg, mqfb_ram and mqfb_mac.
//
//   channel | ports                                         | direction
//   req     | req_valid, req_stall, req_sample_in           | in
//   rsp     | rsp_valid, rsp_stall, rsp_filtered, rsp_window_end | out
//   csr     | csr_write_enable, csr_index, csr_write_data   | in, write only
//
// Each sample passes from its beat through the accept state, the reads of all 129 taps through
// the shared MAC, the drain states and the result state before the next beat can be taken.
// After a window's last beat the tail is rebuilt for every enabled channel, one read and one write per entry.
// After reset the whole tail store is cleared, one entry a cycle (8192 entries by default).
// req_stall is high whenever a sample is in work; a result held by rsp_stall holds the block.
module multichannel_q15_fir_bandpass_unit #(
   parameter int CH_MAX  = mqfb_pkg::CH_MAX_DEF,
   parameter int WIN_MAX = mqfb_pkg::WIN_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [15:0]          req_sample_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_filtered,
   output logic                        rsp_window_end,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [mqfb_pkg::CFG_W-1:0]  csr_write_data
);

   localparam int CHW  = (CH_MAX > 1) ? $clog2(CH_MAX) : 1;
   localparam int TW   = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
   localparam int WAW  = CHW + TW;
   localparam int TAW  = CHW + mqfb_pkg::TAIL_AW;
   localparam int NW   = 14;

   mqfb_pkg::state_type state_ff, state_in;

   logic [6:0]     cc_ff;
   logic [9:0]     wl_ff;
   logic [11:0]    hop_ff;
   logic [TW-1:0]  t_ff, t_in;
   logic [CHW-1:0] ch_ff, ch_in;
   logic [7:0]     k_ff, k_in;
   logic [1:0]     drn_ff, drn_in;
   logic [TAW-1:0] clr_ff, clr_in;
   logic [CHW-1:0] rc_ff, rc_in;
   logic [6:0]     ri_ff, ri_in;
   logic           rsel_ff, rsel_in;
   logic           kvld_ff, kvld_in;
   logic           ksel_ff, ksel_in;
   logic [7:0]     kd_ff;

   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_filtered_ff;
   logic                 rsp_window_end_ff;
   logic                 rsp_load;

   logic           win_we;
   logic [WAW-1:0] win_waddr, win_raddr;
   logic [15:0]    win_rdata;
   logic           tail_we;
   logic [TAW-1:0] tail_waddr, tail_raddr;
   logic [15:0]    tail_wdata, tail_rdata;

   mqfb_pkg::mac_ctrl_type mac_ctrl;
   logic signed [15:0]     mac_sample;
   logic signed [15:0]     mac_result;

   logic [NW-1:0]  ech, ewin, t_x, k_x, diff, hop_x, i_x, ih, keep, nmin, src, widx;
   logic           last;
   logic           req_acc;

   always_comb begin
      ech  = (cc_ff == 7'd0) ? NW'(1) :
             (NW'(cc_ff) > NW'(CH_MAX)) ? NW'(CH_MAX) : NW'(cc_ff);
      ewin = (wl_ff == 10'd0) ? NW'(1) :
             (NW'(wl_ff) > NW'(WIN_MAX)) ? NW'(WIN_MAX) : NW'(wl_ff);
      t_x   = NW'(t_ff);
      k_x   = NW'(k_ff);
      diff  = t_x - k_x;
      hop_x = NW'(hop_ff);
      i_x   = NW'(ri_ff);
      ih    = i_x + hop_x;
      keep  = NW'(mqfb_pkg::HIST_LEN) - hop_x;
      nmin  = (hop_x < ewin) ? hop_x : ewin;
      src   = (hop_x < ewin) ? hop_x - NW'(mqfb_pkg::HIST_LEN)
                             : ewin - NW'(mqfb_pkg::HIST_LEN);
      widx  = src + i_x;
      last  = (t_x == ewin - NW'(1)) && (NW'(ch_ff) == ech - NW'(1));
   end

   assign req_stall = (state_ff != mqfb_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqfb_pkg::ST_TCLR;
         cc_ff    <= 7'd1;
         wl_ff    <= 10'd160;
         hop_ff   <= 12'd80;
         t_ff     <= '0;
         ch_ff    <= '0;
         k_ff     <= '0;
         drn_ff   <= '0;
         clr_ff   <= '0;
         rc_ff    <= '0;
         ri_ff    <= '0;
         rsel_ff  <= 1'b0;
         kvld_ff  <= 1'b0;
         ksel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         t_ff     <= t_in;
         ch_ff    <= ch_in;
         k_ff     <= k_in;
         drn_ff   <= drn_in;
         clr_ff   <= clr_in;
         rc_ff    <= rc_in;
         ri_ff    <= ri_in;
         rsel_ff  <= rsel_in;
         kvld_ff  <= kvld_in;
         ksel_ff  <= ksel_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               mqfb_pkg::REG_CHANNEL_COUNT: cc_ff  <= csr_write_data[6:0];
               mqfb_pkg::REG_WINDOW_LENGTH: wl_ff  <= csr_write_data[9:0];
               mqfb_pkg::REG_HOP_LENGTH:    hop_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kd_ff <= k_ff;
      if (rsp_load) begin
         rsp_filtered_ff   <= mac_result;
         rsp_window_end_ff <= last;
      end
   end

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      ch_in    = ch_ff;
      k_in     = k_ff;
      drn_in   = drn_ff;
      clr_in   = clr_ff;
      rc_in    = rc_ff;
      ri_in    = ri_ff;
      rsel_in  = rsel_ff;
      kvld_in  = 1'b0;
      ksel_in  = 1'b0;
      rsp_load = 1'b0;
      win_we     = 1'b0;
      win_waddr  = {ch_ff, t_ff};
      win_raddr  = {ch_ff, diff[TW-1:0]};
      tail_we    = 1'b0;
      tail_waddr = clr_ff;
      tail_wdata = '0;
      tail_raddr = {ch_ff, diff[6:0]};
      mac_ctrl.clear = 1'b0;
      mac_ctrl.valid = kvld_ff;
      unique case (state_ff)
         mqfb_pkg::ST_TCLR: begin
            tail_we = 1'b1;
            clr_in  = clr_ff + TAW'(1);
            if (&clr_ff) state_in = mqfb_pkg::ST_IDLE;
         end
         mqfb_pkg::ST_IDLE: begin
            if (req_acc) begin
               win_we         = 1'b1;
               mac_ctrl.clear = 1'b1;
               k_in           = '0;
               state_in       = mqfb_pkg::ST_FIR;
            end
         end
         mqfb_pkg::ST_FIR: begin
            // taps at or below t come from the window, older ones from the tail
            kvld_in = 1'b1;
            ksel_in = (k_x <= t_x);
            k_in    = k_ff + 8'd1;
            if (k_ff == 8'(mqfb_pkg::TAPS_DEF - 1)) begin
               drn_in   = '0;
               state_in = mqfb_pkg::ST_DRAIN;
            end
         end
         mqfb_pkg::ST_DRAIN: begin
            drn_in = drn_ff + 2'd1;
            if (drn_ff == 2'd2) state_in = mqfb_pkg::ST_RESULT;
         end
         mqfb_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               if (NW'(ch_ff) + NW'(1) >= ech) begin
                  ch_in = '0;
                  t_in  = t_ff + TW'(1);
               end else begin
                  ch_in = ch_ff + CHW'(1);
               end
               if (last) begin
                  t_in     = '0;
                  ch_in    = '0;
                  rc_in    = '0;
                  ri_in    = '0;
                  state_in = mqfb_pkg::ST_REB_RD;
               end else begin
                  state_in = mqfb_pkg::ST_IDLE;
               end
            end
         end
         mqfb_pkg::ST_REB_RD: begin
            state_in = mqfb_pkg::ST_REB_WR;
            rsel_in  = 1'b1;
            if (hop_x < NW'(mqfb_pkg::HIST_LEN)) begin
               if (i_x < keep) begin
                  rsel_in    = 1'b0;
                  tail_raddr = {rc_ff, ih[6:0]};
               end else if (NW'(ih[6:0]) < nmin) begin
                  win_raddr  = {rc_ff, TW'(ih[6:0])};
               end else begin
                  state_in   = mqfb_pkg::ST_REB_WR;
                  rsel_in    = 1'b0;
                  // position past the appended samples keeps its contents
                  tail_raddr = {rc_ff, ri_ff};
               end
            end else if (ewin >= NW'(mqfb_pkg::HIST_LEN)) begin
               win_raddr = {rc_ff, widx[TW-1:0]};
            end else if (i_x < ewin) begin
               win_raddr = {rc_ff, TW'(ri_ff)};
            end else begin
               rsel_in    = 1'b0;
               tail_raddr = {rc_ff, ri_ff};
            end
         end
         mqfb_pkg::ST_REB_WR: begin
            tail_we    = 1'b1;
            tail_waddr = {rc_ff, ri_ff};
            tail_wdata = rsel_ff ? win_rdata : tail_rdata;
            ri_in      = ri_ff + 7'd1;
            state_in   = mqfb_pkg::ST_REB_RD;
            if (&ri_ff) begin
               rc_in = rc_ff + CHW'(1);
               if (NW'(rc_ff) + NW'(1) >= ech) state_in = mqfb_pkg::ST_IDLE;
            end
         end
         default: state_in = mqfb_pkg::ST_IDLE;
      endcase
      // a write to a listed register restarts the window
      if (csr_write_enable && (csr_index != mqfb_pkg::REG_UNLISTED)) begin
         t_in  = '0;
         ch_in = '0;
      end
   end

   assign mac_sample = ksel_ff ? win_rdata : tail_rdata;

   mqfb_ram #(
      .WIDTH (16),
      .DEPTH (1 << WAW)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_waddr),
      .wr_data (req_sample_in),
      .rd_addr (win_raddr),
      .rd_data (win_rdata)
   );

   mqfb_ram #(
      .WIDTH (16),
      .DEPTH (1 << TAW)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_we),
      .wr_addr (tail_waddr),
      .wr_data (tail_wdata),
      .rd_addr (tail_raddr),
      .rd_data (tail_rdata)
   );

   mqfb_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .coef   (mqfb_pkg::coef_at(kd_ff)),
      .sample (mac_sample),
      .result (mac_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered   = rsp_filtered_ff;
   assign rsp_window_end = rsp_window_end_ff;

`ifndef SYNTHESIS
   a_stall_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> req_stall) else $error("sample taken during tail clear");
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall) else $error("second beat taken while filtering");
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqfb_pkg::ST_FIR) |-> (k_ff < 8'(mqfb_pkg::TAPS_DEF)))
      else $error("tap counter overran");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall)) else $error("held result overwritten");
`endif

endmodule
